// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/core/olt_pkg.sv =====
// Types and constants of the ordered value list table.
package olt_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int IN_W    = ((MODE_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_W   = ((1 + COUNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    mode_t in_mode;
    mode_t mode;
    logic  empty;
    logic  hit;
    logic  last;
  } status_t;

endpackage

// ===== rtl/core/ordered_value_list_table.sv =====
// Ordered value list table: the entries are walked through a memory with one read and one
// write port, one entry per cycle. An item is accepted, search and delete scan the held
// entries for its value, a removal compacts each slot from the removed entry to the tail,
// and the result is handed to the output register once that register is free. Remove-head
// skips the scan; append and any operation on an empty list go straight to the hand-off.
// A new transaction is taken while the previous result still waits in the output register.
module ordered_value_list_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [olt_pkg::IN_W-1:0]  s_tdata,  // mode[1:0], value[33:2], zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [olt_pkg::OUT_W-1:0] m_tdata   // ok[0], count[5:1], zero pad
);
  import olt_pkg::*;

  cmd_t    cmd;
  status_t status;

  olt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  olt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .status   (status),
    .out_data (m_tdata)
  );

endmodule

// ===== rtl/core/olt_dp.sv =====
// Datapath of the list table: entry memory, walk index, fill count and result register.
`include "assert_macros.svh"

module olt_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  olt_pkg::cmd_t            cmd,
  input  logic [olt_pkg::IN_W-1:0] in_data,
  output olt_pkg::status_t         status,
  output logic [olt_pkg::OUT_W-1:0] out_data
);
  import olt_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;

  mode_t              in_mode;
  logic [VALUE_W-1:0] in_value;
  mode_t              mode;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   idx;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  idx_inc;
  logic               full;
  logic               ok;
  logic               out_ok;
  logic [COUNT_W-1:0] out_count;

  assign in_mode  = mode_t'(in_data[MODE_W-1:0]);
  assign in_value = in_data[MODE_W +: VALUE_W];
  assign full     = (fill == FILL_W'(DEPTH));
  assign idx_inc  = FILL_W'(idx) + FILL_W'(1);

  assign status.in_mode = in_mode;
  assign status.mode    = mode;
  assign status.empty   = (fill == '0);
  assign status.hit     = (rd_data == value);
  assign status.last    = (idx_inc == fill);

  // A shift needs the entry above the current slot, one read ahead of the write.
  always_comb begin
    if (cmd.accept) begin
      rd_addr = (in_mode == MODE_POP) ? IDX_W'(1) : '0;
    end else if (cmd.scan) begin
      rd_addr = idx + IDX_W'(1);
    end else begin
      rd_addr = idx + IDX_W'(2);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (cmd.accept && in_mode == MODE_APPEND && !full) begin
      wr_en   = 1'b1;
      wr_addr = fill[IDX_W-1:0];
      wr_data = in_value;
    end else if (cmd.shift && !status.last) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.accept && in_mode == MODE_APPEND && !full) begin
      fill <= fill + FILL_W'(1);
    end else if (cmd.shift && status.last) begin
      fill <= fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode  <= in_mode;
      value <= in_value;
      idx   <= '0;
      case (in_mode)
        MODE_APPEND: ok <= !full;
        MODE_POP:    ok <= !status.empty;
        default:     ok <= 1'b0;
      endcase
    end else if (cmd.scan) begin
      if (status.hit) begin
        ok <= 1'b1;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end else if (cmd.shift && !status.last) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_ok    <= ok;
      out_count <= COUNT_W'(fill);
    end
  end

  assign out_data = OUT_W'({out_count, out_ok});

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill > FILL_W'(DEPTH), "fill count above depth")
  `ASSERT_NEVER(a_scan_in_range, clk, rst, cmd.scan && (FILL_W'(idx) >= fill),
                "scan beyond held entries")
  `ASSERT_PROP(a_shift_end, clk, rst,
               (cmd.shift && status.last) |=> (fill == $past(fill) - FILL_W'(1)),
               "compaction did not drop one entry")

endmodule

// ===== rtl/core/olt_ctrl.sv =====
// Controller of the list table: sequences accept, scan, compaction and result hand-off.
`include "assert_macros.svh"

module olt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  olt_pkg::status_t status,
  output olt_pkg::cmd_t    cmd
);
  import olt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (status.in_mode)
            MODE_APPEND: state_next = ST_DONE;
            MODE_POP:    state_next = status.empty ? ST_DONE : ST_SHIFT;
            default:     state_next = status.empty ? ST_DONE : ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          state_next = (status.mode == MODE_SEARCH) ? ST_DONE : ST_SHIFT;
        end else if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.scan     = 1'b0;
    cmd.shift    = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = !rst;
        cmd.accept = s_tvalid && !rst;
      end
      ST_SCAN:  cmd.scan     = 1'b1;
      ST_SHIFT: cmd.shift    = 1'b1;
      ST_DONE:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_PROP(a_one_in_flight, clk, rst, cmd.accept |=> !s_tready,
               "second transaction taken while one is in progress")
  `ASSERT_PROP(a_result_loaded, clk, rst, cmd.load_out |=> m_tvalid,
               "result loaded but not offered")
  `ASSERT_PROP(a_result_held, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid,
               "result withdrawn before it was taken")

endmodule

// ===== tb/ordered_value_list_table_test.sv =====
// Self-checking testbench for the ordered value list table.
`timescale 1ns / 1ps

module ordered_value_list_table_test;
  import olt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Shadow copy of the list, updated as each transaction is accepted.
  logic [VALUE_W-1:0] list_vals [DEPTH];
  int                 list_len = 0;
  list_result_t       result_q [$];
  list_result_t       want;

  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;
  int hold_req = 0;

  int err_count = 0;
  int checked_count = 0;
  int refused_count = 0;
  int full_refusals = 0;
  int op_tally [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  ordered_value_list_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Applies one operation to the shadow list and queues the result it must produce.
  function automatic void apply_to_list(mode_t m, logic [VALUE_W-1:0] v);
    int i;
    int hit_at;
    int gap_at;
    logic ok;
    list_result_t r;
    hit_at = -1;
    gap_at = -1;
    ok = 1'b0;
    for (i = list_len - 1; i >= 0; i--) begin
      if (list_vals[i] == v) hit_at = i;
    end
    case (m)
      MODE_APPEND: begin
        if (list_len < DEPTH) begin
          list_vals[list_len] = v;
          list_len++;
          ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      MODE_POP: begin
        if (list_len > 0) gap_at = 0;
      end
      MODE_SEARCH: begin
        ok = (hit_at >= 0);
      end
      default: begin
        gap_at = hit_at;
      end
    endcase
    if (gap_at >= 0) begin
      for (i = gap_at; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
      list_len--;
      ok = 1'b1;
    end
    if (!ok) refused_count++;
    op_tally[m]++;
    r.ok = ok;
    r.count = COUNT_W'(list_len);
    result_q.push_back(r);
  endfunction

  // Offers one operation and returns at the edge where it is accepted.
  task automatic offer_op(mode_t m, logic [VALUE_W-1:0] v);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({v, m});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_to_list(m, v);
  endtask

  function automatic mode_t pick_mode(int grow_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < grow_pct) return MODE_APPEND;
    case (pick % 3)
      0:       return MODE_POP;
      1:       return MODE_SEARCH;
      default: return MODE_DELETE;
    endcase
  endfunction

  // Mostly small or already-held values, so duplicates, hits and deletes are common.
  function automatic logic [VALUE_W-1:0] pick_value(mode_t m);
    int sel;
    sel = $urandom_range(0, 9);
    if (list_len > 0 && sel < 5 && m != MODE_APPEND)
      return list_vals[$urandom_range(0, list_len - 1)];
    if (sel < 8) return $urandom_range(0, 7) - 32'd4;
    return $urandom;
  endfunction

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left == 0 && sink_gaps && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 18);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction: ok=%0b count=%0d",
               m_tdata[0], m_tdata[COUNT_W:1]);
        err_count++;
      end else begin
        want = result_q.pop_front();
        checked_count++;
        if (m_tdata[0] !== want.ok) begin
          $error("field ok: expected %0b, actual %0b", want.ok, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[COUNT_W:1] !== want.count) begin
          $error("field count: expected %0d, actual %0d", want.count, m_tdata[COUNT_W:1]);
          err_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    offer_op(MODE_POP, 32'h0);
    offer_op(MODE_DELETE, 32'h7FFF_FFFF);
    offer_op(MODE_SEARCH, 32'h0);
  endtask

  // Fills every slot with extreme and repeated values, then appends once more.
  task automatic test_fill_and_full();
    logic [VALUE_W-1:0] fill_vals [16];
    int i;
    fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'd5, 32'd9,
                  32'd5, 32'd1, 32'd2, 32'd3,
                  32'hFFFF_FFFE, 32'd4, 32'd5, 32'h77};
    for (i = 0; i < DEPTH; i++) offer_op(MODE_APPEND, fill_vals[i % 16]);
    offer_op(MODE_APPEND, 32'h1234_5678);
  endtask

  task automatic test_lookup_and_delete();
    offer_op(MODE_SEARCH, 32'd5);
    offer_op(MODE_SEARCH, 32'd6);
    offer_op(MODE_DELETE, 32'd5);
    offer_op(MODE_DELETE, 32'h77);
    offer_op(MODE_DELETE, 32'h8000_0000);
    offer_op(MODE_POP, 32'hFFFF_FFFF);
    offer_op(MODE_DELETE, 32'h1234_5678);
  endtask

  // Each 40-item segment picks at random how strongly the list grows or drains, so it
  // is driven towards both empty and full.
  task automatic test_random_traffic(int n_items, bit with_gaps);
    int k;
    int grow_pct;
    mode_t m;
    grow_pct = 40;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       grow_pct = 15;
          1:       grow_pct = 40;
          default: grow_pct = 75;
        endcase
        src_gaps = with_gaps && ($urandom_range(0, 2) != 0);
        sink_gaps = with_gaps && ($urandom_range(0, 2) != 0);
      end
      m = pick_mode(grow_pct);
      offer_op(m, pick_value(m));
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so a result
  // stays waiting in the output register and the block has to drop s_tready.
  task automatic test_backpressure();
    int k;
    mode_t m;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_req = 320;
    for (k = 0; k < 48; k++) begin
      m = pick_mode(45);
      offer_op(m, pick_value(m));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    test_empty_list();
    test_fill_and_full();
    test_lookup_and_delete();
    test_random_traffic(420, 1'b1);
    test_backpressure();
    test_random_traffic(220, 1'b0);
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d append, %0d remove-head, %0d search and %0d delete operations.",
             op_tally[MODE_APPEND], op_tally[MODE_POP], op_tally[MODE_SEARCH],
             op_tally[MODE_DELETE]);
    $display("%0d results compared; %0d operations refused, %0d of them on a full list.",
             checked_count, refused_count, full_refusals);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/olt_pkg.sv
rtl/core/olt_dp.sv
rtl/core/olt_ctrl.sv
rtl/core/ordered_value_list_table.sv
tb/ordered_value_list_table_test.sv
